[rtl/core/pwt_pkg.sv]
// Package for the pen waypoint trajectory block.
// Holds the sequencer states, the serial arithmetic request and the saturation helpers.
// It has no dependencies.
package pwt_pkg;

  typedef enum logic [4:0] {
    S_IDLE, S_RD_CUR, S_GOT_CUR, S_GOT_PREV, S_DIFF, S_DUR0, S_SQX, S_SQY, S_ROOT,
    S_DUR1, S_STEPX, S_STEPY, S_PHASE, S_VMUL, S_VDIV, S_HORIZ, S_ADVX, S_ADVY, S_OUT
  } state_e;

  typedef enum logic [1:0] {
    OP_MUL, OP_DIV, OP_SQRT
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               pen;
  } wp_t;

  typedef enum logic [2:0] {
    REG_COUNT, REG_ORIGIN_X, REG_ORIGIN_Y, REG_HOLD_H, REG_WRITE_H, REG_VSPEED,
    REG_HSPEED, REG_DWELL
  } reg_e;

  function automatic logic signed [31:0] add_sat(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      add_sat = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      add_sat = s[31:0];
    end
  endfunction

  function automatic logic signed [31:0] offs_sat(logic signed [31:0] base, logic [65:0] off,
                                                  logic neg);
    logic signed [67:0] s;
    s = neg ? ({{36{base[31]}}, base} - {2'b00, off}) : ({{36{base[31]}}, base} + {2'b00, off});
    if (!s[67] && (|s[66:31])) begin
      offs_sat = 32'sh7fff_ffff;
    end else if (s[67] && !(&s[66:31])) begin
      offs_sat = 32'sh8000_0000;
    end else begin
      offs_sat = s[31:0];
    end
  endfunction

  function automatic logic [31:0] satu32(logic [65:0] v);
    satu32 = (|v[65:32]) ? 32'hffff_ffff : v[31:0];
  endfunction

  function automatic logic [31:0] step_mag(logic [65:0] v, logic neg);
    if (neg) begin
      step_mag = ((|v[65:32]) || (v[31] && (|v[30:0]))) ? 32'h8000_0000 : v[31:0];
    end else begin
      step_mag = (|v[65:31]) ? 32'h7fff_ffff : v[31:0];
    end
  endfunction

endpackage

[rtl/core/pen_waypoint_trajectory.sv]
// Top level of the pen waypoint trajectory setpoint generator.
// Holds the waypoint table, the segment sequencer and the setpoint registers.
// Depends on pwt_pkg and pwt_serial_alu.
//
//   channel | direction | transaction carries
//   in      | sink      | action, wp_index, wp_x, wp_y, wp_pen, time_now, uav_x/y/z
//   out     | source    | set_x, set_y, set_z, active (one per tick)
//   cfg     | sink      | cfg_index, cfg_data (always ready)
//
// A load is written to the table when it is accepted. A tick past the last waypoint goes
// straight to the output step; a tick on a prepared segment runs the serial multiply and
// divide that its phase needs. A tick that starts a new segment first runs its divisions,
// squares and square root, one bit per cycle, and skips the step divisions when the
// horizontal duration is zero. Reset clears all control state; the table needs no
// clearing. One item is handled at a time, and a pending result stalls only the next
// tick's final output step.
module pen_waypoint_trajectory #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic [3:0]         wp_index_i,
  input  logic signed [31:0] wp_x_i,
  input  logic signed [31:0] wp_y_i,
  input  logic               wp_pen_i,
  input  logic [31:0]        time_now_i,
  input  logic signed [31:0] uav_x_i,
  input  logic signed [31:0] uav_y_i,
  input  logic signed [31:0] uav_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] set_x_o,
  output logic signed [31:0] set_y_o,
  output logic signed [31:0] set_z_o,
  output logic               active_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import pwt_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_DEPTH);

  state_e state_q, state_d;

  logic [4:0]         wcount_q;
  logic signed [31:0] org_x_q, org_y_q, hold_h_q, write_h_q;
  logic [30:0]        vspeed_q, hspeed_q, dwell_q;

  wp_t                mem [TABLE_DEPTH];
  wp_t                rd_q;
  logic [8:0]         wr_slot, rd_idx;

  logic [4:0]         seg_q;
  logic               prepared_q, pen_state_q, pen_cur_q, issued_q, act_q, out_valid_q;
  logic [31:0]        pst_q, now_q, dur0_q, dur1_q, stepx_q, stepy_q, el_q;
  logic signed [31:0] uav_x_q, uav_y_q, uav_z_q;
  logic signed [31:0] sx_q, sy_q, sz_q, tx_q, ty_q, tz_q;
  logic signed [31:0] px_q, py_q, pz_q, last_x_q, last_y_q, last_z_q;
  logic [32:0]        ax_q, ay_q, az_q, dist_q;
  logic               dxn_q, dyn_q, dzn_q;
  logic [65:0]        sq_q;

  alu_req_t           alu_req;
  logic [65:0]        alu_a, alu_res;
  logic [32:0]        alu_b, vs_eff, hs_eff;
  logic               alu_done, op_state;

  logic [8:0]         count9;
  logic               run, in_acc, tick_acc, out_go;
  logic [31:0]        el;
  logic               vert, ge0, end0, ge1, end1;
  logic signed [32:0] dx, dy, dz;

  assign count9   = (9'(wcount_q) > 9'(TABLE_DEPTH)) ? 9'(TABLE_DEPTH) : 9'(wcount_q);
  assign run      = 9'(seg_q) < count9;
  assign in_ready_o = state_q == S_IDLE;
  assign in_acc   = in_valid_i && in_ready_o;
  assign tick_acc = in_acc && action_i;
  assign out_go   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);
  assign cfg_ready_o = 1'b1;

  assign vs_eff = (vspeed_q == '0) ? 33'd1 : 33'(vspeed_q);
  assign hs_eff = (hspeed_q == '0) ? 33'd1 : 33'(hspeed_q);

  assign el   = now_q - pst_q;
  assign vert = pen_cur_q != pen_state_q;
  assign ge0  = el >= dur0_q;
  assign end0 = {1'b0, el} >= ({1'b0, dur0_q} + {2'b00, dwell_q});
  assign ge1  = el_q >= dur1_q;
  assign end1 = {1'b0, el_q} >= ({1'b0, dur1_q} + {2'b00, dwell_q});

  assign dx = {tx_q[31], tx_q} - {sx_q[31], sx_q};
  assign dy = {ty_q[31], ty_q} - {sy_q[31], sy_q};
  assign dz = {tz_q[31], tz_q} - {sz_q[31], sz_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcount_q  <= '0;
      org_x_q   <= '0;
      org_y_q   <= '0;
      hold_h_q  <= 32'sd65536;
      write_h_q <= 32'sd32768;
      vspeed_q  <= 31'd65536;
      hspeed_q  <= 31'd65536;
      dwell_q   <= 31'd65536;
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_COUNT:    wcount_q  <= cfg_data_i[4:0];
        REG_ORIGIN_X: org_x_q   <= cfg_data_i;
        REG_ORIGIN_Y: org_y_q   <= cfg_data_i;
        REG_HOLD_H:   hold_h_q  <= cfg_data_i;
        REG_WRITE_H:  write_h_q <= cfg_data_i;
        REG_VSPEED:   vspeed_q  <= cfg_data_i[30:0];
        REG_HSPEED:   hspeed_q  <= cfg_data_i[30:0];
        default:      dwell_q   <= cfg_data_i[30:0];
      endcase
    end
  end

  assign wr_slot = 9'(wp_index_i);
  assign rd_idx  = (state_q == S_RD_CUR) ? 9'(seg_q) : (9'(seg_q) - 9'd1);

  always_ff @(posedge clk_i) begin
    if (in_acc && !action_i && (wr_slot < 9'(TABLE_DEPTH))) begin
      mem[wr_slot[IW-1:0]] <= '{x: wp_x_i, y: wp_y_i, pen: wp_pen_i};
    end
    rd_q <= mem[rd_idx[IW-1:0]];
  end

  pwt_serial_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .opa_i  (alu_a),
    .opb_i  (alu_b),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  always_comb begin
    state_d  = state_q;
    op_state = 1'b0;
    alu_req  = '{start: 1'b0, op: OP_MUL};
    alu_a    = '0;
    alu_b    = '0;
    unique case (state_q)
      S_IDLE:     if (tick_acc) state_d = run ? S_RD_CUR : S_OUT;
      S_RD_CUR:   state_d = S_GOT_CUR;
      S_GOT_CUR:  state_d = prepared_q ? S_PHASE : S_GOT_PREV;
      S_GOT_PREV: state_d = S_DIFF;
      S_DIFF:     state_d = S_DUR0;
      S_DUR0: begin
        op_state   = 1'b1;
        alu_req.op = OP_DIV;
        alu_a      = 66'(az_q) << FRAC_BITS;
        alu_b      = vs_eff;
        if (alu_done) state_d = S_SQX;
      end
      S_SQX: begin
        op_state = 1'b1;
        alu_a    = 66'(ax_q);
        alu_b    = ax_q;
        if (alu_done) state_d = S_SQY;
      end
      S_SQY: begin
        op_state = 1'b1;
        alu_a    = 66'(ay_q);
        alu_b    = ay_q;
        if (alu_done) state_d = S_ROOT;
      end
      S_ROOT: begin
        op_state   = 1'b1;
        alu_req.op = OP_SQRT;
        alu_a      = sq_q;
        if (alu_done) state_d = S_DUR1;
      end
      S_DUR1: begin
        op_state   = 1'b1;
        alu_req.op = OP_DIV;
        alu_a      = 66'(dist_q) << FRAC_BITS;
        alu_b      = hs_eff;
        if (alu_done) state_d = (satu32(alu_res) == '0) ? S_PHASE : S_STEPX;
      end
      S_STEPX: begin
        op_state   = 1'b1;
        alu_req.op = OP_DIV;
        alu_a      = 66'(ax_q) << FRAC_BITS;
        alu_b      = 33'(dur1_q);
        if (alu_done) state_d = S_STEPY;
      end
      S_STEPY: begin
        op_state   = 1'b1;
        alu_req.op = OP_DIV;
        alu_a      = 66'(ay_q) << FRAC_BITS;
        alu_b      = 33'(dur1_q);
        if (alu_done) state_d = S_PHASE;
      end
      S_PHASE: begin
        priority if (!vert || end0) begin
          state_d = S_HORIZ;
        end else if (ge0) begin
          state_d = S_OUT;
        end else begin
          state_d = S_VMUL;
        end
      end
      S_VMUL: begin
        op_state = 1'b1;
        alu_a    = 66'(az_q);
        alu_b    = 33'(el_q);
        if (alu_done) state_d = S_VDIV;
      end
      S_VDIV: begin
        op_state   = 1'b1;
        alu_req.op = OP_DIV;
        alu_a      = sq_q;
        alu_b      = 33'(dur0_q);
        if (alu_done) state_d = S_OUT;
      end
      S_HORIZ:    state_d = ge1 ? S_OUT : S_ADVX;
      S_ADVX: begin
        op_state = 1'b1;
        alu_a    = 66'(stepx_q);
        alu_b    = 33'(el_q);
        if (alu_done) state_d = S_ADVY;
      end
      S_ADVY: begin
        op_state = 1'b1;
        alu_a    = 66'(stepy_q);
        alu_b    = 33'(el_q);
        if (alu_done) state_d = S_OUT;
      end
      S_OUT:      if (out_go) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
    alu_req.start = op_state && !issued_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issued_q    <= 1'b0;
      seg_q       <= '0;
      prepared_q  <= 1'b0;
      pen_state_q <= 1'b0;
      pst_q       <= '0;
      tz_q        <= '0;
      last_x_q    <= '0;
      last_y_q    <= '0;
      last_z_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (alu_done) begin
        issued_q <= 1'b0;
      end else if (alu_req.start) begin
        issued_q <= 1'b1;
      end
      if (state_q == S_GOT_CUR && !prepared_q) begin
        tz_q <= rd_q.pen ? write_h_q : hold_h_q;
      end
      if (state_q == S_PHASE) begin
        prepared_q <= 1'b1;
        if (vert && end0) begin
          pst_q       <= now_q;
          pen_state_q <= pen_cur_q;
        end
      end
      if (state_q == S_HORIZ && ge1 && end1) begin
        pst_q      <= now_q;
        prepared_q <= 1'b0;
        seg_q      <= seg_q + 5'd1;
      end
      if (out_go && act_q) begin
        last_x_q <= px_q;
        last_y_q <= py_q;
        last_z_q <= pz_q;
      end
      if (out_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      now_q   <= time_now_i;
      uav_x_q <= uav_x_i;
      uav_y_q <= uav_y_i;
      uav_z_q <= uav_z_i;
      px_q    <= last_x_q;
      py_q    <= last_y_q;
      pz_q    <= last_z_q;
      act_q   <= run;
    end
    unique case (state_q)
      S_GOT_CUR: begin
        pen_cur_q <= rd_q.pen;
        if (!prepared_q) begin
          tx_q <= add_sat(org_x_q, rd_q.x);
          ty_q <= add_sat(org_y_q, rd_q.y);
          sz_q <= (seg_q == '0) ? uav_z_q : tz_q;
        end
      end
      S_GOT_PREV: begin
        sx_q <= (seg_q == '0) ? uav_x_q : add_sat(org_x_q, rd_q.x);
        sy_q <= (seg_q == '0) ? uav_y_q : add_sat(org_y_q, rd_q.y);
      end
      S_DIFF: begin
        dxn_q <= dx[32];
        dyn_q <= dy[32];
        dzn_q <= dz[32];
        ax_q  <= dx[32] ? 33'(-dx) : 33'(dx);
        ay_q  <= dy[32] ? 33'(-dy) : 33'(dy);
        az_q  <= dz[32] ? 33'(-dz) : 33'(dz);
      end
      S_DUR0:  if (alu_done) dur0_q <= satu32(alu_res);
      S_SQX:   if (alu_done) sq_q <= alu_res;
      S_SQY:   if (alu_done) sq_q <= sq_q + alu_res;
      S_ROOT:  if (alu_done) dist_q <= alu_res[32:0];
      S_DUR1: begin
        if (alu_done) begin
          dur1_q  <= satu32(alu_res);
          stepx_q <= '0;
          stepy_q <= '0;
        end
      end
      S_STEPX: if (alu_done) stepx_q <= step_mag(alu_res, dxn_q);
      S_STEPY: if (alu_done) stepy_q <= step_mag(alu_res, dyn_q);
      S_PHASE: begin
        el_q <= (vert && end0) ? 32'd0 : el;
        if (vert) begin
          px_q <= sx_q;
          py_q <= sy_q;
          if (ge0) pz_q <= tz_q;
        end
      end
      S_VMUL:  if (alu_done) sq_q <= alu_res;
      S_VDIV:  if (alu_done) pz_q <= offs_sat(sz_q, alu_res, dzn_q);
      S_HORIZ: begin
        pz_q <= tz_q;
        if (ge1) begin
          px_q <= tx_q;
          py_q <= ty_q;
        end
      end
      S_ADVX:  if (alu_done) px_q <= offs_sat(sx_q, alu_res >> FRAC_BITS, dxn_q);
      S_ADVY:  if (alu_done) py_q <= offs_sat(sy_q, alu_res >> FRAC_BITS, dyn_q);
      S_OUT: begin
        if (out_go) begin
          set_x_o  <= px_q;
          set_y_o  <= py_q;
          set_z_o  <= pz_q;
          active_o <= act_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/core/pwt_serial_alu.sv]
// Bit-serial arithmetic unit: shift-add multiply, restoring divide and digit square root.
// Depends on pwt_pkg.
module pwt_serial_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pwt_pkg::alu_req_t req_i,
  input  logic [65:0]       opa_i,
  input  logic [32:0]       opb_i,
  output logic              done_o,
  output logic [65:0]       res_o
);
  import pwt_pkg::*;

  logic        busy_q, busy_d, done_q, done_d;
  alu_op_e     op_q, op_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [66:0] acc_q, acc_d;
  logic [36:0] rem_q, rem_d;
  logic [32:0] root_q, root_d;
  logic [32:0] opb_q, opb_d;

  logic [33:0] mul_sum, div_t;
  logic        div_ge, sq_ge;
  logic [36:0] sq_t, sq_trial;

  assign mul_sum  = acc_q[66:33] + (acc_q[0] ? {1'b0, opb_q} : 34'd0);
  assign div_t    = {rem_q[32:0], acc_q[65]};
  assign div_ge   = div_t >= {1'b0, opb_q};
  assign sq_t     = {rem_q[34:0], acc_q[65:64]};
  assign sq_trial = {2'b00, root_q, 2'b01};
  assign sq_ge    = sq_t >= sq_trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    root_d = root_q;
    opb_d  = opb_q;
    if (!busy_q) begin
      if (req_i.start) begin
        busy_d = 1'b1;
        op_d   = req_i.op;
        rem_d  = '0;
        root_d = '0;
        unique case (req_i.op)
          OP_MUL: begin
            acc_d = {34'd0, opb_i};
            opb_d = opa_i[32:0];
            cnt_d = 7'd32;
          end
          OP_DIV: begin
            acc_d = {1'b0, opa_i};
            opb_d = opb_i;
            cnt_d = 7'd65;
          end
          default: begin
            acc_d = {1'b0, opa_i};
            opb_d = opb_i;
            cnt_d = 7'd32;
          end
        endcase
      end
    end else begin
      unique case (op_q)
        OP_MUL: acc_d = {1'b0, mul_sum, acc_q[32:1]};
        OP_DIV: begin
          rem_d = div_ge ? 37'(div_t - {1'b0, opb_q}) : 37'(div_t);
          acc_d = {1'b0, acc_q[64:0], div_ge};
        end
        default: begin
          rem_d  = sq_ge ? (sq_t - sq_trial) : sq_t;
          root_d = {root_q[31:0], sq_ge};
          acc_d  = {1'b0, acc_q[63:0], 2'b00};
        end
      endcase
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_MUL;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    opb_q  <= opb_d;
  end

  assign done_o = done_q;
  assign res_o  = (op_q == OP_SQRT) ? 66'(root_q) : acc_q[65:0];

endmodule
